// File: rtl/adf_pkg.sv
`default_nettype none
package adf_pkg;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		CFG_FLUX_MODE = 2'd0,
		CFG_STEP_GAIN = 2'd1,
		CFG_INV_KAPPA = 2'd2
	} cfg_idx_t;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 17;

	localparam logic [15:0] STEP_GAIN_RST = 16'd10923;
	localparam logic [16:0] INV_KAPPA_RST = 17'd4096;

	// conduction datapath widths
	localparam int S_BITS   = 21;             // s in Q.16, clamped at 16.0
	localparam int C_BITS   = 17;             // conduction, 65536 is 1.0
	localparam int DEN_BITS = 22;
	localparam int QUO_BITS = 20;             // restoring quotient incl. leading zeros
	localparam int DIV_STG  = 5;
	localparam int DIV_STEP = 4;

	localparam logic [S_BITS-1:0] S_MAX     = 21'h100000;
	localparam logic [16:0]       LOG2E_Q16 = 17'd94548;

	// round(65536 * 2^(-i/16))
	function automatic logic [16:0] pow2_neg(input logic [4:0] idx);
		logic [16:0] v;
		case (idx)
			5'd0:    v = 17'd65536;
			5'd1:    v = 17'd62757;
			5'd2:    v = 17'd60097;
			5'd3:    v = 17'd57549;
			5'd4:    v = 17'd55109;
			5'd5:    v = 17'd52773;
			5'd6:    v = 17'd50535;
			5'd7:    v = 17'd48393;
			5'd8:    v = 17'd46341;
			5'd9:    v = 17'd44376;
			5'd10:   v = 17'd42495;
			5'd11:   v = 17'd40693;
			5'd12:   v = 17'd38968;
			5'd13:   v = 17'd37316;
			5'd14:   v = 17'd35734;
			5'd15:   v = 17'd34219;
			5'd16:   v = 17'd32768;
			default: v = 17'd32768;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// File: rtl/adf_if.sv
`default_nettype none
interface adf_win_if #(parameter int PIXEL_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] centre_pixel;
	logic [PIXEL_BITS-1:0] north_pixel;
	logic [PIXEL_BITS-1:0] south_pixel;
	logic [PIXEL_BITS-1:0] east_pixel;
	logic [PIXEL_BITS-1:0] west_pixel;
	logic [PIXEL_BITS-1:0] northeast_pixel;
	logic [PIXEL_BITS-1:0] southeast_pixel;
	logic [PIXEL_BITS-1:0] southwest_pixel;
	logic [PIXEL_BITS-1:0] northwest_pixel;

	modport source (output valid, centre_pixel, north_pixel, south_pixel, east_pixel,
		west_pixel, northeast_pixel, southeast_pixel, southwest_pixel, northwest_pixel,
		input ready);
	modport sink (input valid, centre_pixel, north_pixel, south_pixel, east_pixel,
		west_pixel, northeast_pixel, southeast_pixel, southwest_pixel, northwest_pixel,
		output ready);
endinterface

interface adf_res_if #(parameter int PIXEL_BITS = 16);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] updated_pixel;
	logic                  clipped;

	modport source (output valid, updated_pixel, clipped, input ready);
	modport sink (input valid, updated_pixel, clipped, output ready);
endinterface
`default_nettype wire

// File: rtl/anisotropic_diffusion_pixel_update.sv
// an accepted window's result reaches the output after passing the registered stages tracked by vld_s
// throughput: one window per cycle; the whole pipeline advances together and holds on a stall
// rational conduction uses a five-stage restoring divider per neighbour
// reset: asynchronous active low, clears all valid bits and loads the register defaults
`default_nettype none
module anisotropic_diffusion_pixel_update #(
	parameter int PIXEL_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	adf_win_if.sink                                 px_in,
	adf_res_if.source                               px_out,
	input  wire logic                               cfg_we,
	input  wire logic [adf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [adf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import adf_pkg::*;

	localparam int P      = PIXEL_BITS;
	localparam int PW     = P + 18;        // one c*d product
	localparam int AW     = PW + 4;        // weighted sum of eight
	localparam int LO     = 24;            // split point of the gain multiply
	localparam int HW     = AW - LO;
	localparam int TOTW   = P + 40;
	localparam int LAST   = 15;

	// configuration registers
	logic        flux_mode_q;
	logic [15:0] step_gain_q;
	logic [16:0] inv_kappa_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flux_mode_q <= 1'b0;
			step_gain_q <= STEP_GAIN_RST;
			inv_kappa_q <= INV_KAPPA_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FLUX_MODE: flux_mode_q <= cfg_data[0];
				CFG_STEP_GAIN: step_gain_q <= cfg_data[15:0];
				CFG_INV_KAPPA: inv_kappa_q <= cfg_data[16:0];
				default:       ;
			endcase
		end
	end

	// single pipeline enable: move on whenever the output slot is free or being taken
	logic            en;
	logic [1:LAST]   vld_s;

	assign en          = !vld_s[LAST] || px_out.ready;
	assign px_in.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {px_in.valid, vld_s[1:LAST-1]};
		end
	end

	// centre value travels alongside for the final add
	logic [P-1:0] ctr_pipe_s [1:LAST-2];

	always_ff @(posedge clk) begin
		if (en) begin
			ctr_pipe_s[1] <= px_in.centre_pixel;
			for (int i = 2; i < LAST-1; i++) ctr_pipe_s[i] <= ctr_pipe_s[i-1];
		end
	end

	// eight conduction lanes: axial first, then diagonal
	logic [P-1:0]         nb [0:7];
	logic signed [PW-1:0] prod_s10 [0:7];

	assign nb[0] = px_in.north_pixel;
	assign nb[1] = px_in.south_pixel;
	assign nb[2] = px_in.east_pixel;
	assign nb[3] = px_in.west_pixel;
	assign nb[4] = px_in.northeast_pixel;
	assign nb[5] = px_in.southeast_pixel;
	assign nb[6] = px_in.southwest_pixel;
	assign nb[7] = px_in.northwest_pixel;

	for (genvar n = 0; n < 8; n++) begin : g_lane
		adf_lane #(.PIXEL_BITS(P)) u_lane (
			.clk       (clk),
			.en        (en),
			.flux_mode (flux_mode_q),
			.inv_kappa (inv_kappa_q),
			.ctr       (px_in.centre_pixel),
			.nb        (nb[n]),
			.prod_s10  (prod_s10[n])
		);
	end

	// adder tree, axial pairs weighted twice against diagonal
	logic signed [PW:0]      ax01_s11, ax23_s11, dg01_s11, dg23_s11;
	logic signed [AW-1:0]    acc_s12;
	logic [LO+15:0]          plo_s13;
	logic signed [HW+16:0]   phi_s13;
	logic signed [TOTW-1:0]  total_s14;
	logic [P-1:0]            upd_s15;
	logic                    clip_s15;
	logic [TOTW-34:0]        res;

	assign res = total_s14[TOTW-1:33];

	always_ff @(posedge clk) begin
		if (en) begin
			ax01_s11 <= (PW+1)'(prod_s10[0]) + (PW+1)'(prod_s10[1]);
			ax23_s11 <= (PW+1)'(prod_s10[2]) + (PW+1)'(prod_s10[3]);
			dg01_s11 <= (PW+1)'(prod_s10[4]) + (PW+1)'(prod_s10[5]);
			dg23_s11 <= (PW+1)'(prod_s10[6]) + (PW+1)'(prod_s10[7]);
			acc_s12  <= ((AW'(ax01_s11) + AW'(ax23_s11)) <<< 1)
				+ AW'(dg01_s11) + AW'(dg23_s11);
			// gain multiply cut into an unsigned low and a signed high partial
			plo_s13  <= acc_s12[LO-1:0] * step_gain_q;
			phi_s13  <= $signed(acc_s12[AW-1:LO]) * $signed({1'b0, step_gain_q});
			// centre in Q.33 plus half an lsb for rounding
			total_s14 <= (TOTW'(phi_s13) <<< LO) + $signed(TOTW'(plo_s13))
				+ $signed(TOTW'(ctr_pipe_s[LAST-2]) << 33)
				+ $signed(TOTW'(1) << 32);
			if (total_s14 < 0) begin
				upd_s15  <= '0;
				clip_s15 <= 1'b1;
			end else if (res > (TOTW-33)'({P{1'b1}})) begin
				upd_s15  <= {P{1'b1}};
				clip_s15 <= 1'b1;
			end else begin
				upd_s15  <= res[P-1:0];
				clip_s15 <= 1'b0;
			end
		end
	end

	assign px_out.valid         = vld_s[LAST];
	assign px_out.updated_pixel = upd_s15;
	assign px_out.clipped       = clip_s15;

`ifndef NO_ASSERTIONS
	// a saturated result sits at one of the range limits
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		px_out.valid && px_out.clipped
		|-> (px_out.updated_pixel == '0 || px_out.updated_pixel == {P{1'b1}}))
		else $error("clipped result not at a range limit");

	// an accepted request enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		px_in.valid && px_in.ready |=> vld_s[1])
		else $error("accepted request lost at pipeline entry");

	// a stalled output blocks the input side
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		px_out.valid && !px_out.ready |-> !px_in.ready)
		else $error("input taken while output stalled");
`endif

endmodule
`default_nettype wire

// File: rtl/adf_lane.sv
`default_nettype none
module adf_lane #(
	parameter int PIXEL_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic                      flux_mode,
	input  wire logic [16:0]               inv_kappa,
	input  wire logic [PIXEL_BITS-1:0]     ctr,
	input  wire logic [PIXEL_BITS-1:0]     nb,
	output logic signed [PIXEL_BITS+17:0]  prod_s10
);
	import adf_pkg::*;

	localparam int P  = PIXEL_BITS;
	localparam int DW = P + 1;
	localparam int TW = P + 17;

	function automatic logic [DEN_BITS+QUO_BITS-1:0] div_steps(
		input logic [DEN_BITS-1:0] r_in,
		input logic [QUO_BITS-1:0] q_in,
		input logic [DEN_BITS-1:0] den,
		input logic [DIV_STEP-1:0] nbits
	);
		logic [DEN_BITS-1:0] r;
		logic [QUO_BITS-1:0] q;
		r = r_in;
		q = q_in;
		for (int i = DIV_STEP - 1; i >= 0; i--) begin
			r = {r[DEN_BITS-2:0], nbits[i]};
			q = {q[QUO_BITS-2:0], 1'b0};
			if (r >= den) begin
				r    = r - den;
				q[0] = 1'b1;
			end
		end
		return {r, q};
	endfunction

	// difference, magnitude times 1/kappa, square
	logic signed [DW-1:0] d_pipe_s [1:9];
	logic [P-1:0]         mag;
	logic [TW-1:0]        t_s2;
	logic [35:0]          tt;
	logic [36:0]          tt_rnd;
	logic [S_BITS-1:0]    s_s3;
	logic [37:0]          su;
	logic [38:0]          su_rnd;
	logic [22:0]          u_s4;
	logic [DEN_BITS-1:0]  den_s4;

	assign mag    = d_pipe_s[1][DW-1] ? P'(-d_pipe_s[1]) : P'(d_pipe_s[1]);
	assign tt     = t_s2[17:0] * t_s2[17:0];
	assign tt_rnd = {1'b0, tt} + 37'd32768;
	assign su     = s_s3 * LOG2E_Q16;
	assign su_rnd = {1'b0, su} + 39'd32768;

	always_ff @(posedge clk) begin
		if (en) begin
			d_pipe_s[1] <= $signed({1'b0, nb}) - $signed({1'b0, ctr});
			for (int i = 2; i <= 9; i++) d_pipe_s[i] <= d_pipe_s[i-1];
			t_s2 <= TW'(mag) * TW'(inv_kappa);
			if (t_s2 >= TW'(32'h40000))
				s_s3 <= S_MAX;
			else if (tt_rnd[36:16] > S_MAX)
				s_s3 <= S_MAX;
			else
				s_s3 <= tt_rnd[36:16];
			u_s4   <= su_rnd[38:16];
			den_s4 <= DEN_BITS'(32'h10000) + DEN_BITS'(s_s3);
		end
	end

	// exponential branch: table lookup, interpolation, then shift by k
	logic [6:0]  k_full;
	logic [4:0]  tab_idx;
	logic [16:0] tab_a, tab_b, tab_diff;
	logic [28:0] interp;
	logic [29:0] interp_rnd;
	logic [16:0] v_s5;
	logic [4:0]  k_s5;
	logic        zero_s5;
	logic [17:0] v_rnd;
	logic [C_BITS-1:0] ce_s6, ce_s7, ce_s8, ce_s9;

	assign k_full     = u_s4[22:16];
	assign tab_idx    = {1'b0, u_s4[15:12]};
	assign tab_a      = pow2_neg(tab_idx);
	assign tab_b      = pow2_neg(tab_idx + 5'd1);
	assign tab_diff   = tab_a - tab_b;
	assign interp     = tab_diff * u_s4[11:0];
	assign interp_rnd = {1'b0, interp} + 30'd2048;
	assign v_rnd      = {1'b0, v_s5} + (18'd1 << (k_s5 - 5'd1));

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s5 <= (k_full > 7'd16);
			k_s5    <= k_full[4:0];
			v_s5    <= tab_a - interp_rnd[28:12];
			if (zero_s5)
				ce_s6 <= '0;
			else if (k_s5 == 5'd0)
				ce_s6 <= v_s5;
			else
				ce_s6 <= C_BITS'(v_rnd >> k_s5);
			ce_s7 <= ce_s6;
			ce_s8 <= ce_s7;
			ce_s9 <= ce_s8;
		end
	end

	// rational branch: pipelined restoring divide of 2^32 + den/2 by den
	logic [DEN_BITS-1:0] div_rem_s [0:DIV_STG];
	logic [QUO_BITS-1:0] div_quo_s [0:DIV_STG];
	logic [DEN_BITS-1:0] div_den_s [0:DIV_STG];
	logic [QUO_BITS-1:0] div_num_s [0:DIV_STG];

	// numerator bits above the quotient range form the first remainder
	assign div_rem_s[0] = DEN_BITS'(32'h1000) + DEN_BITS'(den_s4[DEN_BITS-1]);
	assign div_quo_s[0] = '0;
	assign div_den_s[0] = den_s4;
	assign div_num_s[0] = den_s4[QUO_BITS:1];

	for (genvar j = 0; j < DIV_STG; j++) begin : g_div
		logic [DEN_BITS+QUO_BITS-1:0] nxt;
		assign nxt = div_steps(div_rem_s[j], div_quo_s[j], div_den_s[j],
			div_num_s[j][QUO_BITS-1-DIV_STEP*j -: DIV_STEP]);
		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s[j+1] <= nxt[DEN_BITS+QUO_BITS-1:QUO_BITS];
				div_quo_s[j+1] <= nxt[QUO_BITS-1:0];
				div_den_s[j+1] <= div_den_s[j];
				div_num_s[j+1] <= div_num_s[j];
			end
		end
	end

	logic [C_BITS-1:0] c_sel;

	assign c_sel = flux_mode ? div_quo_s[DIV_STG][C_BITS-1:0] : ce_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s10 <= $signed({{(P+1){1'b0}}, c_sel}) * (P+18)'(d_pipe_s[9]);
		end
	end

endmodule
`default_nettype wire
